### hw/rtl/mrs_pkg.sv
// Shared types and constants for the maximal rectangle row scanner.
// No dependencies; imported by every module of the block.
package mrs_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

    localparam int AREA_W = 17;
    localparam logic [AREA_W-1:0] AREA_MAX = 17'h1FFFF;

    localparam int GRP_LANES = 8;

    typedef struct packed {
        logic load;
        logic clear;
        logic area_go;
    } mrs_lane_ctl_t;

    typedef struct packed {
        logic grp_go;
        logic out_go;
        logic last;
    } mrs_merge_ctl_t;

endpackage

### hw/rtl/mrs_scan.sv
// Row scan stage: prefix scan of zero positions (left starts) and suffix scan (right starts).
// Depends on mrs_pkg.
module mrs_scan #(
    parameter int MAX_COLS = mrs_pkg::MAX_COLS_DEF,
    localparam int CW = $clog2(MAX_COLS + 1)
) (
    input  logic                clk,
    input  logic                load,
    input  logic [MAX_COLS-1:0] row_bits,
    input  logic [CW-1:0]       n,
    output logic [CW-1:0]       lstart [MAX_COLS],
    output logic [CW-1:0]       rstart [MAX_COLS],
    output logic [MAX_COLS-1:0] ones,
    output logic [MAX_COLS-1:0] act
);
    import mrs_pkg::*;

    localparam int LV = $clog2(MAX_COLS);

    logic [MAX_COLS-1:0] act_c;
    logic [MAX_COLS-1:0] zero_c;
    logic [CW-1:0]       lp [LV+1][MAX_COLS];
    logic [CW-1:0]       rp [LV+1][MAX_COLS];

    logic [CW-1:0]       lstart_reg [MAX_COLS];
    logic [CW-1:0]       rstart_reg [MAX_COLS];
    logic [MAX_COLS-1:0] ones_reg;
    logic [MAX_COLS-1:0] act_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_COLS; j++)
        begin
            act_c[j]  = CW'(j) < n;
            zero_c[j] = act_c[j] && !row_bits[j];
        end
        for (int j = 0; j < MAX_COLS; j++)
        begin
            lp[0][j] = '0;
            rp[0][j] = n;
            if (j > 0 && zero_c[j-1])
            begin
                lp[0][j] = CW'(j);
            end
            if (j < MAX_COLS - 1 && zero_c[j+1])
            begin
                rp[0][j] = CW'(j + 1);
            end
        end
        // log-depth max / min scans
        for (int s = 0; s < LV; s++)
        begin
            for (int j = 0; j < MAX_COLS; j++)
            begin
                lp[s+1][j] = lp[s][j];
                rp[s+1][j] = rp[s][j];
                if (j >= (1 << s) && lp[s][j-(1<<s)] > lp[s][j])
                begin
                    lp[s+1][j] = lp[s][j-(1<<s)];
                end
                if (j + (1 << s) < MAX_COLS && rp[s][j+(1<<s)] < rp[s][j])
                begin
                    rp[s+1][j] = rp[s][j+(1<<s)];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int j = 0; j < MAX_COLS; j++)
            begin
                lstart_reg[j] <= lp[LV][j];
                rstart_reg[j] <= rp[LV][j];
            end
            ones_reg <= row_bits & act_c;
            act_reg  <= act_c;
        end
    end

    assign lstart = lstart_reg;
    assign rstart = rstart_reg;
    assign ones   = ones_reg;
    assign act    = act_reg;

endmodule

### hw/rtl/mrs_lane.sv
// One column lane: run height and bounds, then the saturated width-times-height area.
// Depends on mrs_pkg.
module mrs_lane #(
    parameter int MAX_COLS = mrs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mrs_pkg::MAX_ROWS_DEF,
    localparam int CW = $clog2(MAX_COLS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mrs_pkg::mrs_lane_ctl_t      ctl,
    input  logic                        one,
    input  logic                        act,
    input  logic [CW-1:0]               lstart,
    input  logic [CW-1:0]               rstart,
    input  logic [CW-1:0]               n,
    output logic [mrs_pkg::AREA_W-1:0]  area
);
    import mrs_pkg::*;

    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int PW = CW + HW;
    localparam int XW = (PW > AREA_W) ? PW : AREA_W;

    logic [HW-1:0]     height_reg, height_next;
    logic [CW-1:0]     left_reg, left_next;
    logic [CW-1:0]     right_reg, right_next;
    logic [CW-1:0]     width_reg, width_next;
    logic [HW-1:0]     h_reg;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [PW-1:0]     prod;
    logic [XW-1:0]     prod_x;

    always_comb
    begin
        height_next = height_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        if (act)
        begin
            if (one)
            begin
                if (height_reg != HW'(MAX_ROWS))
                begin
                    height_next = height_reg + 1'b1;
                end
                if (lstart > left_reg)
                begin
                    left_next = lstart;
                end
                if (rstart < right_reg)
                begin
                    right_next = rstart;
                end
            end
            else
            begin
                height_next = '0;
                left_next   = '0;
                right_next  = n;
            end
        end
        width_next = '0;
        if (act && right_next > left_next)
        begin
            width_next = right_next - left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= '0;
            left_reg   <= '0;
            right_reg  <= CW'(MAX_COLS);
        end
        else if (ctl.load)
        begin
            if (ctl.clear)
            begin
                height_reg <= '0;
                left_reg   <= '0;
                right_reg  <= n;
            end
            else
            begin
                height_reg <= height_next;
                left_reg   <= left_next;
                right_reg  <= right_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            width_reg <= width_next;
            h_reg     <= height_next;
        end
        if (ctl.area_go)
        begin
            area_reg <= area_next;
        end
    end

    always_comb
    begin
        prod   = PW'(width_reg) * PW'(h_reg);
        prod_x = XW'(prod);
        if (prod_x > XW'(AREA_MAX))
        begin
            area_next = AREA_MAX;
        end
        else
        begin
            area_next = AREA_W'(prod_x);
        end
    end

    assign area = area_reg;

endmodule

### hw/rtl/mrs_merge.sv
// Merge stage: registered max over lane groups, then best-so-far update and output register.
// Depends on mrs_pkg.
module mrs_merge #(
    parameter int MAX_COLS = mrs_pkg::MAX_COLS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mrs_pkg::mrs_merge_ctl_t     ctl,
    input  logic [mrs_pkg::AREA_W-1:0]  area [MAX_COLS],
    output logic [mrs_pkg::AREA_W-1:0]  best_area,
    output logic                        matrix_done
);
    import mrs_pkg::*;

    localparam int GROUPS = (MAX_COLS + GRP_LANES - 1) / GRP_LANES;

    logic [AREA_W-1:0] grp_reg [GROUPS];
    logic [AREA_W-1:0] grp_next [GROUPS];
    logic [AREA_W-1:0] row_max;
    logic [AREA_W-1:0] best_next;
    logic [AREA_W-1:0] best_reg;
    logic [AREA_W-1:0] best_area_reg;
    logic              matrix_done_reg;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_LANES; k++)
            begin
                if (g * GRP_LANES + k < MAX_COLS)
                begin
                    if (area[g*GRP_LANES+k] > grp_next[g])
                    begin
                        grp_next[g] = area[g*GRP_LANES+k];
                    end
                end
            end
        end
    end

    always_comb
    begin
        row_max = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            if (grp_reg[g] > row_max)
            begin
                row_max = grp_reg[g];
            end
        end
        best_next = (row_max > best_reg) ? row_max : best_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.grp_go)
        begin
            grp_reg <= grp_next;
        end
        if (ctl.out_go)
        begin
            best_area_reg   <= best_next;
            matrix_done_reg <= ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (ctl.out_go)
        begin
            best_reg <= ctl.last ? '0 : best_next;
        end
    end

    assign best_area   = best_area_reg;
    assign matrix_done = matrix_done_reg;

endmodule

### hw/rtl/maximal_rectangle_row_scan.sv
// Top level of the maximal all-ones rectangle row scanner.
// Depends on mrs_pkg, mrs_scan, mrs_lane and mrs_merge.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one matrix row per beat: row_bits,
//   bit j is column j, and last_row marking the final row of a matrix.
//   Output channel (out_valid / out_stall) returns one beat per row: best_area,
//   the largest all-ones area so far in the matrix, and matrix_done on the last row.
//   Config channel (cfg_valid / cfg_ready / cfg_data) sets the column count; it is
//   always ready. The user must write it only while the block is idle; the block
//   does not enforce this. Input beats pass the registered stages scan, lane update,
//   lane multiply, group max and best compare. Throughput is one row per cycle while
//   out_stall is low; the lane update feeds its per-column state back on itself.
//   Reset clears column heights, bounds and the best area; column count becomes 64.
//   When the receiver stalls, stages fill up behind the output register, and
//   in_stall rises only once the stage behind the scan cannot move.
module maximal_rectangle_row_scan #(
    parameter int MAX_COLS = mrs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mrs_pkg::MAX_ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [MAX_COLS-1:0]         row_bits,
    input  logic                        last_row,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mrs_pkg::AREA_W-1:0]  best_area,
    output logic                        matrix_done,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mrs_pkg::CFG_W-1:0]   cfg_data
);
    import mrs_pkg::*;

    localparam int CW = $clog2(MAX_COLS + 1);

    logic [CFG_W-1:0] cols_reg;
    logic [CW-1:0]    n_act;

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic last1_reg, last2_reg, last3_reg, last4_reg;
    logic go1, go2, go3, go4, go5;

    logic [CW-1:0]       lstart [MAX_COLS];
    logic [CW-1:0]       rstart [MAX_COLS];
    logic [MAX_COLS-1:0] ones;
    logic [MAX_COLS-1:0] act;
    logic [AREA_W-1:0]   area [MAX_COLS];

    mrs_lane_ctl_t  lane_ctl;
    mrs_merge_ctl_t merge_ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cols_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (cols_reg == '0)
        begin
            n_act = CW'(1);
        end
        else if (cols_reg > CFG_W'(MAX_COLS))
        begin
            n_act = CW'(MAX_COLS);
        end
        else
        begin
            n_act = CW'(cols_reg);
        end
    end

    // stage hand-off, bubbles collapse
    assign go5      = v4_reg && (!out_valid_reg || !out_stall);
    assign go4      = v3_reg && (!v4_reg || go5);
    assign go3      = v2_reg && (!v3_reg || go4);
    assign go2      = v1_reg && (!v2_reg || go3);
    assign in_stall = v1_reg && !go2;
    assign go1      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= go1 || (v1_reg && !go2);
            v2_reg        <= go2 || (v2_reg && !go3);
            v3_reg        <= go3 || (v3_reg && !go4);
            v4_reg        <= go4 || (v4_reg && !go5);
            out_valid_reg <= go5 || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (go1)
        begin
            last1_reg <= last_row;
        end
        if (go2)
        begin
            last2_reg <= last1_reg;
        end
        if (go3)
        begin
            last3_reg <= last2_reg;
        end
        if (go4)
        begin
            last4_reg <= last3_reg;
        end
    end

    assign lane_ctl.load     = go2;
    assign lane_ctl.clear    = last1_reg;
    assign lane_ctl.area_go  = go3;
    assign merge_ctl.grp_go  = go4;
    assign merge_ctl.out_go  = go5;
    assign merge_ctl.last    = last4_reg;

    mrs_scan #(
        .MAX_COLS (MAX_COLS)
    ) u_scan (
        .clk      (clk),
        .load     (go1),
        .row_bits (row_bits),
        .n        (n_act),
        .lstart   (lstart),
        .rstart   (rstart),
        .ones     (ones),
        .act      (act)
    );

    for (genvar j = 0; j < MAX_COLS; j++)
    begin : g_lane
        mrs_lane #(
            .MAX_COLS (MAX_COLS),
            .MAX_ROWS (MAX_ROWS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lane_ctl),
            .one    (ones[j]),
            .act    (act[j]),
            .lstart (lstart[j]),
            .rstart (rstart[j]),
            .n      (n_act),
            .area   (area[j])
        );
    end

    mrs_merge #(
        .MAX_COLS (MAX_COLS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (merge_ctl),
        .area        (area),
        .best_area   (best_area),
        .matrix_done (matrix_done)
    );

    assign out_valid = out_valid_reg;

endmodule

### sim/maximal_rectangle_row_scan_tb.sv
// Testbench for maximal_rectangle_row_scan: rows go in, best-area beats are checked
// against an in-bench model of the column scans. Depends on mrs_pkg and the block RTL.
`timescale 1ns / 100ps

module maximal_rectangle_row_scan_tb;

    import mrs_pkg::*;

    localparam int NUM_COLS     = 64;
    localparam int ROW_CAP      = 1024;
    localparam int PIPE_LATENCY = 5;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ROWS  = 250;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic              done;
    } area_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [NUM_COLS-1:0] row_bits = '0;
    logic                last_row = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [AREA_W-1:0]   best_area;
    logic                matrix_done;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;

    // model state
    logic [CFG_W-1:0]    model_cols;
    int unsigned         col_height [NUM_COLS];
    int unsigned         col_left   [NUM_COLS];
    int unsigned         col_right  [NUM_COLS];
    int unsigned         model_best;

    area_beat_t          expected_areas[$];
    int                  rows_sent = 0;
    int                  results_seen = 0;
    int                  mismatches = 0;
    int                  cycle_count = 0;
    bit                  quiet = 1'b0;
    logic                hold_off = 1'b0;
    int                  stall_left = 0;
    event                hold_trigger;

    maximal_rectangle_row_scan #(
        .MAX_COLS (NUM_COLS),
        .MAX_ROWS (ROW_CAP)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .row_bits    (row_bits),
        .last_row    (last_row),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .best_area   (best_area),
        .matrix_done (matrix_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned active_columns();
        int unsigned n;
        n = model_cols;
        if (n < 1) n = 1;
        if (n > NUM_COLS) n = NUM_COLS;
        return n;
    endfunction

    function automatic void clear_matrix_state();
        int unsigned n;
        n = active_columns();
        for (int j = 0; j < NUM_COLS; j++)
        begin
            col_height[j] = 0;
            col_left[j]   = 0;
            col_right[j]  = n;
        end
        model_best = 0;
    endfunction

    function automatic area_beat_t predict_area(logic [NUM_COLS-1:0] row, logic last);
        int unsigned n;
        int unsigned lstart;
        int unsigned rstart;
        longint unsigned w;
        longint unsigned a;
        area_beat_t beat;
        n = active_columns();
        lstart = 0;
        rstart = n;
        for (int j = 0; j < n; j++)
        begin
            if (row[j])
            begin
                if (col_height[j] < ROW_CAP) col_height[j]++;
                if (col_left[j] < lstart) col_left[j] = lstart;
            end
            else
            begin
                col_height[j] = 0;
                col_left[j]   = 0;
                lstart        = j + 1;
            end
        end
        for (int c = n - 1; c >= 0; c--)
        begin
            if (row[c])
            begin
                if (col_right[c] > rstart) col_right[c] = rstart;
            end
            else
            begin
                col_right[c] = n;
                rstart       = c;
            end
        end
        for (int j = 0; j < n; j++)
        begin
            w = (col_right[j] > col_left[j]) ? (col_right[j] - col_left[j]) : 0;
            a = w * col_height[j];
            if (a > AREA_MAX) a = AREA_MAX;
            if (a > model_best) model_best = 32'(a);
        end
        beat.area = model_best[AREA_W-1:0];
        beat.done = last;
        if (last) clear_matrix_state();
        return beat;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [NUM_COLS-1:0] rand_row();
        return {$urandom, $urandom};
    endfunction

    task automatic send_row(input logic [NUM_COLS-1:0] row, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        row_bits <= row;
        last_row <= last;
        do
            @(posedge clk);
        while (in_stall);
        expected_areas.insert(expected_areas.size(), predict_area(row, last));
        rows_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_areas.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_columns(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        model_cols  = value;
    endtask

    // result checker
    always @(posedge clk)
    begin
        area_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_areas.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d with nothing pending: area %0d done %0b",
                             results_seen, best_area, matrix_done);
            end
            else
            begin
                want = expected_areas.pop_front();
                if (best_area !== want.area || matrix_done !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result %0d: expected area %0d done %0b, got area %0d done %0b",
                                 results_seen, want.area, want.done, best_area, matrix_done);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (quiet || r < 75)
            out_stall <= 1'b0;
        else if (r < 95)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(10, 40);
        end
    end

    // long receiver hold-off
    always
    begin
        @(hold_trigger);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        send_row(64'h0000_0000_0000_0001, 1'b1);
        wait_for_results();
    endtask

    task automatic test_field_extremes();
        send_row(64'h8000_0000_0000_0000, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b0);
        send_row(64'hFFFF_FFFF_0000_FFFF, 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_0FFF, 1'b0);
        send_row('0, 1'b0);
        send_row(64'h7FFF_FFFF_FFFF_FFFE, 1'b1);
        wait_for_results();
    endtask

    task automatic test_column_limits();
        logic [CFG_W-1:0] widths [5];
        widths = '{7'd0, 7'd1, 7'd65, 7'd127, 7'd3};
        foreach (widths[i])
        begin
            write_columns(widths[i]);
            send_row(64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
            send_row('1, 1'b0);
            send_row(64'hFFFF_FFFF_FFFF_FFFB, 1'b1);
            wait_for_results();
        end
        write_columns(COLS_RESET);
    endtask

    task automatic test_mid_matrix_write();
        write_columns(7'd40);
        send_row('1, 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_FF0F, 1'b0);
        wait_for_results();
        write_columns(7'd12);
        send_row('1, 1'b0);
        wait_for_results();
        write_columns(7'd64);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        wait_for_results();
    endtask

    // heights cap at the row bound, area reaches the full width times that bound
    task automatic test_tall_runs();
        write_columns(7'd64);
        for (int i = 0; i < ROW_CAP + 6; i++)
            send_row('1, i == ROW_CAP + 5);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        -> hold_trigger;
        for (int i = 0; i < 40; i++)
            send_row(rand_row() | rand_row(), (i % 10) == 9);
        quiet = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_matrices();
        int style;
        int depth;
        int lo;
        int hi;
        int r;
        int start_count;
        logic [NUM_COLS-1:0] block;
        logic [NUM_COLS-1:0] row;
        start_count = rows_sent;
        while (rows_sent - start_count < RANDOM_ROWS)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                wait_for_results();
                r = $urandom_range(0, 99);
                if (r < 8) write_columns(7'd0);
                else if (r < 16) write_columns(CFG_W'($urandom_range(65, 127)));
                else if (r < 26) write_columns(7'd64);
                else if (r < 34) write_columns(7'd1);
                else write_columns(CFG_W'($urandom_range(1, 64)));
            end
            quiet = ($urandom_range(0, 9) == 0);
            depth = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            lo = $urandom_range(0, NUM_COLS - 1);
            hi = $urandom_range(lo, NUM_COLS - 1);
            block = ({NUM_COLS{1'b1}} >> (NUM_COLS - 1 - (hi - lo))) << lo;
            for (int i = 0; i < depth; i++)
            begin
                style = $urandom_range(0, 99);
                if (style < 20) row = rand_row();
                else if (style < 55) row = rand_row() | rand_row() | rand_row();
                else if (style < 85) row = block | (rand_row() & rand_row());
                else if (style < 95) row = '1;
                else row = '0;
                if (i == depth / 2 && $urandom_range(0, 19) == 0)
                begin
                    wait_for_results();
                    if ($urandom_range(0, 1) == 1) write_columns(CFG_W'($urandom_range(0, 127)));
                end
                send_row(row, i == depth - 1);
            end
        end
        quiet = 1'b0;
        wait_for_results();
    endtask

    initial
    begin
        model_cols = COLS_RESET;
        clear_matrix_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_column_limits();
        test_mid_matrix_write();
        test_tall_runs();
        test_backpressure();
        test_random_matrices();

        wait_for_results();
        if (mismatches == 0 && expected_areas.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
hw/rtl/mrs_pkg.sv
hw/rtl/mrs_scan.sv
hw/rtl/mrs_lane.sv
hw/rtl/mrs_merge.sv
hw/rtl/maximal_rectangle_row_scan.sv
sim/maximal_rectangle_row_scan_tb.sv
